FILE: rtl/dense_dijkstra_shortest_path_top_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the dense shortest path block
// Concurrent checks on clk_i, switched off while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef DENSE_DIJKSTRA_SHORTEST_PATH_TOP_MACROS_SVH
`define DENSE_DIJKSTRA_SHORTEST_PATH_TOP_MACROS_SVH

// Consequent holds in the same cycle as the antecedent.
`define DDSP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define DDSP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/ddsp_pkg.sv
// ---------------------------------------------------------------------------
// ddsp_pkg
// Shared widths, codes and arithmetic helpers of the shortest path block.
// ---------------------------------------------------------------------------
package ddsp_pkg;

  localparam int VERTICES_DEF = 16;
  localparam int IDX_W        = 6;
  localparam int WEIGHT_W     = 16;
  localparam int DIST_W       = 22;

  localparam logic [WEIGHT_W-1:0] NO_EDGE  = {WEIGHT_W{1'b1}};
  localparam logic [DIST_W-1:0]   DIST_INF = {DIST_W{1'b1}};

  typedef enum logic [0:0] {
    ACT_LOAD = 1'b0,
    ACT_RUN  = 1'b1
  } action_e;

  // Distance plus edge weight, saturating at the unreachable value.
  function automatic logic [DIST_W-1:0] sat_add(input logic [DIST_W-1:0]   path_len,
                                                input logic [WEIGHT_W-1:0] weight);
    logic [DIST_W:0] sum;
    sum = {1'b0, path_len} + (DIST_W+1)'(weight);
    return (sum > {1'b0, DIST_INF}) ? DIST_INF : sum[DIST_W-1:0];
  endfunction

endpackage

FILE: rtl/ddsp_if.sv
// ---------------------------------------------------------------------------
// ddsp_in_if / ddsp_out_if
// Valid/ready channels carrying command items in and vertex results out.
// ---------------------------------------------------------------------------
interface ddsp_in_if;
  logic                          valid;
  logic                          ready;
  logic                          action;
  logic [ddsp_pkg::IDX_W-1:0]    row;
  logic [ddsp_pkg::IDX_W-1:0]    col;
  logic [ddsp_pkg::WEIGHT_W-1:0] weight;
  logic [ddsp_pkg::IDX_W-1:0]    src;

  modport source (output valid, action, row, col, weight, src, input ready);
  modport sink (input valid, action, row, col, weight, src, output ready);
endinterface

interface ddsp_out_if;
  logic                        valid;
  logic                        ready;
  logic [ddsp_pkg::IDX_W-1:0]  vertex;
  logic [ddsp_pkg::DIST_W-1:0] distance;
  logic [ddsp_pkg::IDX_W-1:0]  predecessor;
  logic                        reachable;
  logic                        last;

  modport source (output valid, vertex, distance, predecessor, reachable, last,
                  input ready);
  modport sink (input valid, vertex, distance, predecessor, reachable, last,
                output ready);
endinterface

FILE: rtl/ddsp_ram.sv
// ---------------------------------------------------------------------------
// ddsp_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module ddsp_ram #(
  parameter int WIDTH = ddsp_pkg::WEIGHT_W,
  parameter int DEPTH = ddsp_pkg::VERTICES_DEF * ddsp_pkg::VERTICES_DEF,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Hold read data while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/ddsp_ctrl.sv
// ---------------------------------------------------------------------------
// ddsp_ctrl
// Sequencer: store weight loads; initialise, select nearest, relax, stream.
// ---------------------------------------------------------------------------
`include "dense_dijkstra_shortest_path_top_macros.svh"

module ddsp_ctrl #(
  parameter int VERTICES = ddsp_pkg::VERTICES_DEF,
  localparam int VW      = $clog2(VERTICES),
  localparam int AW      = $clog2(VERTICES * VERTICES),
  localparam int VE_W    = ddsp_pkg::DIST_W + VW + 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  ddsp_in_if.sink                       in_i,
  ddsp_out_if.source                    out_o,
  // edge weight memory
  output logic                          eram_we_o,
  output logic [AW-1:0]                 eram_waddr_o,
  output logic [ddsp_pkg::WEIGHT_W-1:0] eram_wdata_o,
  output logic                          eram_re_o,
  output logic [AW-1:0]                 eram_raddr_o,
  input  logic [ddsp_pkg::WEIGHT_W-1:0] eram_rdata_i,
  // vertex state memory
  output logic                          vram_we_o,
  output logic [VW-1:0]                 vram_waddr_o,
  output logic [VE_W-1:0]               vram_wdata_o,
  output logic                          vram_re_o,
  output logic [VW-1:0]                 vram_raddr_o,
  input  logic [VE_W-1:0]               vram_rdata_i
);

  typedef struct packed {
    logic [ddsp_pkg::DIST_W-1:0] cost;
    logic [VW-1:0]               prev;
    logic                        settled;
  } ventry_t;

  typedef enum logic [2:0] {
    S_IDLE, S_INIT, S_SEL, S_DEC, S_REL, S_OUT_RD, S_OUT_LD
  } state_e;

  typedef enum logic [1:0] {
    OP_INIT, OP_SEL, OP_REL
  } op_e;

  state_e                      state_q, state_d;
  logic [VW-1:0]               cnt_q, cnt_d;
  logic [VW-1:0]               src_q, src_d;
  logic [VW-1:0]               k_q, k_d;
  logic [VW-1:0]               bk_q, bk_d;
  logic [AW-1:0]               base_q, base_d;
  logic [ddsp_pkg::DIST_W-1:0] bestk_q, bestk_d;
  logic [ddsp_pkg::DIST_W-1:0] best_q, best_d;
  logic                        found_q, found_d;
  logic                        st_vld_q, st_vld_d;
  op_e                         st_op_q, st_op_d;
  logic [VW-1:0]               st_idx_q, st_idx_d;

  logic                        out_valid_q;
  logic [ddsp_pkg::IDX_W-1:0]  out_vertex_q;
  logic [ddsp_pkg::DIST_W-1:0] out_dist_q;
  logic [ddsp_pkg::IDX_W-1:0]  out_pred_q;
  logic                        out_reach_q;
  logic                        out_last_q;
  logic                        out_load;

  ventry_t                     vrd;
  ventry_t                     vwr;
  logic                        cnt_last;
  logic                        row_ok;
  logic                        col_ok;
  logic                        src_ok;
  logic                        sel_take;
  logic [ddsp_pkg::DIST_W-1:0] best_nx;
  logic [VW-1:0]               bk_nx;
  logic                        found_nx;
  logic [ddsp_pkg::DIST_W-1:0] cand;

  assign vrd          = ventry_t'(vram_rdata_i);
  assign vram_wdata_o = VE_W'(vwr);
  assign cnt_last     = (cnt_q == VW'(VERTICES - 1));
  assign row_ok       = ({1'b0, in_i.row} < 7'(VERTICES));
  assign col_ok       = ({1'b0, in_i.col} < 7'(VERTICES));
  assign src_ok       = ({1'b0, in_i.src} < 7'(VERTICES));

  // Minimum search over the entry returned this cycle; strict compare keeps
  // the lowest index on ties.
  assign sel_take = st_vld_q && (st_op_q == OP_SEL) && !vrd.settled && (vrd.cost < best_q);
  assign best_nx  = sel_take ? vrd.cost : best_q;
  assign bk_nx    = sel_take ? st_idx_q : bk_q;
  assign found_nx = found_q | sel_take;
  assign cand     = ddsp_pkg::sat_add(bestk_q, eram_rdata_i);

  assign eram_wdata_o = in_i.weight;
  assign eram_waddr_o = AW'(AW'(in_i.row[VW-1:0]) * AW'(VERTICES)) + AW'(in_i.col[VW-1:0]);
  assign vram_raddr_o = cnt_q;
  assign vram_waddr_o = st_idx_q;
  assign in_i.ready   = (state_q == S_IDLE);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    src_d     = src_q;
    k_d       = k_q;
    base_d    = base_q;
    bestk_d   = bestk_q;
    best_d    = best_nx;
    bk_d      = bk_nx;
    found_d   = found_nx;
    st_vld_d  = 1'b0;
    st_op_d   = st_op_q;
    st_idx_d  = cnt_q;
    eram_we_o = 1'b0;
    eram_re_o = 1'b0;
    eram_raddr_o = base_q + AW'(cnt_q);
    vram_re_o = 1'b0;
    vram_we_o = 1'b0;
    vwr       = '0;
    out_load  = 1'b0;

    // Write back the entry whose read data arrived this cycle.
    if (st_vld_q) begin
      unique case (st_op_q)
        OP_INIT: begin
          vram_we_o = 1'b1;
          if (st_idx_q == src_q) begin
            vwr = '{cost: '0, prev: src_q, settled: 1'b1};
          end else begin
            vwr.cost    = (eram_rdata_i == ddsp_pkg::NO_EDGE) ? ddsp_pkg::DIST_INF
                                                              : ddsp_pkg::DIST_W'(eram_rdata_i);
            vwr.prev    = src_q;
            vwr.settled = 1'b0;
          end
        end
        OP_REL: begin
          if (st_idx_q == k_q) begin
            vram_we_o = 1'b1;
            vwr       = '{cost: vrd.cost, prev: vrd.prev, settled: 1'b1};
          end else if (!vrd.settled && (eram_rdata_i != ddsp_pkg::NO_EDGE)
                       && (cand < vrd.cost)) begin
            vram_we_o = 1'b1;
            vwr       = '{cost: cand, prev: k_q, settled: 1'b0};
          end
        end
        default: ;
      endcase
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          if (in_i.action == ddsp_pkg::ACT_LOAD) begin
            eram_we_o = row_ok && col_ok;
          end else if (src_ok) begin
            src_d   = in_i.src[VW-1:0];
            base_d  = AW'(AW'(in_i.src[VW-1:0]) * AW'(VERTICES));
            cnt_d   = '0;
            state_d = S_INIT;
          end
        end
      end
      S_INIT: begin
        eram_re_o = 1'b1;
        st_vld_d  = 1'b1;
        st_op_d   = OP_INIT;
        if (cnt_last) begin
          cnt_d   = '0;
          best_d  = ddsp_pkg::DIST_INF;
          found_d = 1'b0;
          state_d = S_SEL;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_SEL: begin
        vram_re_o = 1'b1;
        st_vld_d  = 1'b1;
        st_op_d   = OP_SEL;
        if (cnt_last) begin
          state_d = S_DEC;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_DEC: begin
        cnt_d = '0;
        if (found_nx) begin
          k_d     = bk_nx;
          bestk_d = best_nx;
          base_d  = AW'(AW'(bk_nx) * AW'(VERTICES));
          state_d = S_REL;
        end else begin
          state_d = S_OUT_RD;
        end
      end
      S_REL: begin
        eram_re_o = 1'b1;
        vram_re_o = 1'b1;
        st_vld_d  = 1'b1;
        st_op_d   = OP_REL;
        if (cnt_last) begin
          cnt_d   = '0;
          best_d  = ddsp_pkg::DIST_INF;
          found_d = 1'b0;
          state_d = S_SEL;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_OUT_RD: begin
        vram_re_o = 1'b1;
        state_d   = S_OUT_LD;
      end
      S_OUT_LD: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          if (cnt_last) begin
            state_d = S_IDLE;
          end else begin
            cnt_d   = cnt_q + 1'b1;
            state_d = S_OUT_RD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      st_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
      found_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      st_vld_q <= st_vld_d;
      found_q  <= found_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q    <= cnt_d;
    src_q    <= src_d;
    k_q      <= k_d;
    bk_q     <= bk_d;
    base_q   <= base_d;
    bestk_q  <= bestk_d;
    best_q   <= best_d;
    st_op_q  <= st_op_d;
    st_idx_q <= st_idx_d;
    if (out_load) begin
      out_vertex_q <= ddsp_pkg::IDX_W'(cnt_q);
      out_dist_q   <= vrd.cost;
      out_pred_q   <= ddsp_pkg::IDX_W'(vrd.prev);
      out_reach_q  <= (vrd.cost != ddsp_pkg::DIST_INF);
      out_last_q   <= cnt_last;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.vertex      = out_vertex_q;
  assign out_o.distance    = out_dist_q;
  assign out_o.predecessor = out_pred_q;
  assign out_o.reachable   = out_reach_q;
  assign out_o.last        = out_last_q;

  `DDSP_ASSERT_NOW(a_last_flag, out_valid_q, out_last_q == (out_vertex_q == ddsp_pkg::IDX_W'(VERTICES - 1)), "last flag not on final vertex")
  `DDSP_ASSERT_NOW(a_reach_flag, out_valid_q, out_reach_q == (out_dist_q != ddsp_pkg::DIST_INF), "reachable flag disagrees with distance")
  `DDSP_ASSERT_NEXT(a_run_start, in_i.valid && in_i.ready && (in_i.action == ddsp_pkg::ACT_RUN) && src_ok, state_q == S_INIT, "run item did not start initialisation")
  `DDSP_ASSERT_NOW(a_relax_mono, vram_we_o && st_vld_q && (st_op_q == OP_REL) && (st_idx_q != k_q), vwr.cost >= bestk_q, "relaxed distance below settled vertex")

endmodule

FILE: rtl/dense_dijkstra_shortest_path_top.sv
// ---------------------------------------------------------------------------
// dense_dijkstra_shortest_path_top
// Single-source shortest paths over a dense VERTICES x VERTICES weight matrix.
// ---------------------------------------------------------------------------
// Load items (action 0) write one 16-bit edge weight into the matrix and
// stream at one item per cycle while no run is in progress; a weight of all
// ones means no edge, and a row or column outside the graph is dropped. Every
// matrix entry used by a run must be loaded first. A run item (action 1) names
// the source; a source outside the graph is dropped without results. A run
// initialises the vertex state, then takes up to VERTICES-1 rounds of select,
// decide and relax and one last select and decide that finds nothing; it
// stops early once no reachable unsettled vertex is left. The nearest-vertex
// scan and the relaxation both walk the single read port of the vertex state
// memory in vertex order. Results follow in vertex order, each read from the
// vertex state memory and then loaded into the output register once that is
// free or the sink takes its result, the last one flagged; the next item is
// accepted as soon as the final result sits in the output register. No
// clearing pass is needed after reset: each run rewrites the whole vertex
// state before reading it.
// ---------------------------------------------------------------------------
module dense_dijkstra_shortest_path_top #(
  parameter int VERTICES = ddsp_pkg::VERTICES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ddsp_in_if.sink    in_i,
  ddsp_out_if.source out_o
);

  localparam int VW   = $clog2(VERTICES);
  localparam int AW   = $clog2(VERTICES * VERTICES);
  localparam int VE_W = ddsp_pkg::DIST_W + VW + 1;

  // Edge weight matrix, row-major, written by load items only.
  logic                          eram_we;
  logic [AW-1:0]                 eram_waddr;
  logic [ddsp_pkg::WEIGHT_W-1:0] eram_wdata;
  logic                          eram_re;
  logic [AW-1:0]                 eram_raddr;
  logic [ddsp_pkg::WEIGHT_W-1:0] eram_rdata;

  // Per-vertex distance, predecessor and settled flag. The sequencer reads
  // entry i and writes it back in the next cycle while reading i+1, so a read
  // and a write never meet on the same entry.
  logic                          vram_we;
  logic [VW-1:0]                 vram_waddr;
  logic [VE_W-1:0]               vram_wdata;
  logic                          vram_re;
  logic [VW-1:0]                 vram_raddr;
  logic [VE_W-1:0]               vram_rdata;

  ddsp_ram #(
    .WIDTH (ddsp_pkg::WEIGHT_W),
    .DEPTH (VERTICES * VERTICES)
  ) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (eram_we),
    .waddr_i (eram_waddr),
    .wdata_i (eram_wdata),
    .re_i    (eram_re),
    .raddr_i (eram_raddr),
    .rdata_o (eram_rdata)
  );

  ddsp_ram #(
    .WIDTH (VE_W),
    .DEPTH (VERTICES)
  ) u_vert_ram (
    .clk_i   (clk_i),
    .we_i    (vram_we),
    .waddr_i (vram_waddr),
    .wdata_i (vram_wdata),
    .re_i    (vram_re),
    .raddr_i (vram_raddr),
    .rdata_o (vram_rdata)
  );

  // Sequencer: owns the handshakes, the search and relaxation datapath and
  // the output register.
  ddsp_ctrl #(
    .VERTICES (VERTICES)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .out_o        (out_o),
    .eram_we_o    (eram_we),
    .eram_waddr_o (eram_waddr),
    .eram_wdata_o (eram_wdata),
    .eram_re_o    (eram_re),
    .eram_raddr_o (eram_raddr),
    .eram_rdata_i (eram_rdata),
    .vram_we_o    (vram_we),
    .vram_waddr_o (vram_waddr),
    .vram_wdata_o (vram_wdata),
    .vram_re_o    (vram_re),
    .vram_raddr_o (vram_raddr),
    .vram_rdata_i (vram_rdata)
  );

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Shortest path block testbench
// Fills the weight matrix, then drives directed and random load and run items
// through the command channel. A local Dijkstra predictor queues the expected
// per-vertex results, and the result channel is checked against them in order.
// Both channels idle and stall at random.
// ---------------------------------------------------------------------------
module testbench;

  localparam int VERTICES       = ddsp_pkg::VERTICES_DEF;
  localparam int IDX_W          = ddsp_pkg::IDX_W;
  localparam int WEIGHT_W       = ddsp_pkg::WEIGHT_W;
  localparam int DIST_W         = ddsp_pkg::DIST_W;
  localparam logic [WEIGHT_W-1:0] NO_EDGE = ddsp_pkg::NO_EDGE;
  localparam logic [DIST_W-1:0] DIST_INF  = ddsp_pkg::DIST_INF;
  localparam int CELLS          = VERTICES * VERTICES;
  // The full matrix fill already takes most of the item budget.
  localparam int RANDOM_ITEMS   = 48;
  // Allowance for the worst case compute time of one run.
  localparam int RUN_CYCLES     = 2 * VERTICES * VERTICES + 2 * VERTICES;
  localparam int SETTLE_CYCLES  = RUN_CYCLES + 64;
  localparam int WATCHDOG_LIMIT = 4 * RUN_CYCLES + 400;
  localparam int REPORT_CAP     = 100;

  typedef struct packed {
    ddsp_pkg::action_e   action;
    logic [IDX_W-1:0]    row;
    logic [IDX_W-1:0]    col;
    logic [WEIGHT_W-1:0] weight;
    logic [IDX_W-1:0]    source;
  } path_cmd_t;

  typedef struct packed {
    logic [IDX_W-1:0]  vertex;
    logic [DIST_W-1:0] distance;
    logic [IDX_W-1:0]  predecessor;
    logic              reachable;
    logic              last;
  } vertex_result_t;

  logic clk_i;
  logic rst_ni;

  ddsp_in_if  cmd_bus ();
  ddsp_out_if res_bus ();

  dense_dijkstra_shortest_path_top #(
    .VERTICES(VERTICES)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (cmd_bus),
    .out_o (res_bus)
  );

  // Predictor state: the weight matrix and the per-vertex search state.
  logic [WEIGHT_W-1:0] edge_table [CELLS];
  logic [DIST_W-1:0]   path_dist  [VERTICES];
  logic                path_done  [VERTICES];
  logic [IDX_W-1:0]    path_prev  [VERTICES];

  path_cmd_t      pending_cmds[$];
  vertex_result_t expected_vertices[$];

  int  cmds_total;
  int  cmds_sent;
  int  cmd_gap;
  bit  cmd_taken;
  bit  cmd_calm;
  int  res_stall;
  bit  res_calm;
  int  idle_cycles;
  int  errors;
  int  loads_done;
  int  runs_done;
  int  dropped_items;
  int  results_seen;
  int  unreachable_seen;

  // Clock: 12 ns period.
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Gap length: mostly short, now and then long; none at all in a calm stretch.
  function automatic int pick_gap(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Weight mix: plenty of missing edges, small weights for ties, zeros and
  // near-maximum weights for long distances.
  function automatic logic [WEIGHT_W-1:0] pick_weight();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return NO_EDGE;
    if (r < 50) return WEIGHT_W'($urandom_range(0, 3));
    if (r < 75) return WEIGHT_W'($urandom_range(1, 64));
    if (r < 90) return WEIGHT_W'($urandom_range(0, 65534));
    return WEIGHT_W'($urandom_range(60000, 65534));
  endfunction

  // Queue a weight load; the source field is unused, so give it noise.
  task automatic queue_load(input int row, input int col, input logic [WEIGHT_W-1:0] w);
    path_cmd_t c;
    c.action = ddsp_pkg::ACT_LOAD;
    c.row    = IDX_W'(row);
    c.col    = IDX_W'(col);
    c.weight = w;
    c.source = IDX_W'($urandom_range(0, 63));
    pending_cmds.push_back(c);
  endtask

  // Queue a run; row, col and weight are unused, so give them noise.
  task automatic queue_run(input int src);
    path_cmd_t c;
    c.action = ddsp_pkg::ACT_RUN;
    c.row    = IDX_W'($urandom_range(0, 63));
    c.col    = IDX_W'($urandom_range(0, 63));
    c.weight = WEIGHT_W'($urandom_range(0, 65535));
    c.source = IDX_W'(src);
    pending_cmds.push_back(c);
  endtask

  // Dijkstra from src over edge_table, then queue one result per vertex.
  task automatic solve_paths(input int src);
    int                  best_k;
    bit                  found;
    logic [DIST_W-1:0]   best;
    logic [DIST_W:0]     cand;
    logic [WEIGHT_W-1:0] w;
    vertex_result_t      r;
    for (int i = 0; i < VERTICES; i++) begin
      w = edge_table[src * VERTICES + i];
      path_done[i] = 1'b0;
      path_prev[i] = IDX_W'(src);
      path_dist[i] = (w == NO_EDGE) ? DIST_INF : DIST_W'(w);
    end
    // The source is settled up front, so its self edge never counts.
    path_done[src] = 1'b1;
    path_dist[src] = '0;
    for (int round = 1; round < VERTICES; round++) begin
      best   = DIST_INF;
      best_k = 0;
      found  = 1'b0;
      // Strict compare keeps the lowest index on ties.
      for (int j = 0; j < VERTICES; j++) begin
        if (!path_done[j] && path_dist[j] < best) begin
          best   = path_dist[j];
          best_k = j;
          found  = 1'b1;
        end
      end
      if (!found) break;
      path_done[best_k] = 1'b1;
      for (int j = 0; j < VERTICES; j++) begin
        w = edge_table[best_k * VERTICES + j];
        if (!path_done[j] && w != NO_EDGE) begin
          cand = {1'b0, path_dist[best_k]} + (DIST_W + 1)'(w);
          if (cand > {1'b0, DIST_INF}) cand = {1'b0, DIST_INF};
          if (cand[DIST_W-1:0] < path_dist[j]) begin
            path_dist[j] = cand[DIST_W-1:0];
            path_prev[j] = IDX_W'(best_k);
          end
        end
      end
    end
    for (int v = 0; v < VERTICES; v++) begin
      r.vertex      = IDX_W'(v);
      r.distance    = path_dist[v];
      r.predecessor = path_prev[v];
      r.reachable   = (path_dist[v] != DIST_INF);
      r.last        = (v == VERTICES - 1);
      expected_vertices.push_back(r);
    end
  endtask

  // Apply one accepted item to the predictor state.
  task automatic apply_cmd(input path_cmd_t c);
    if (c.action == ddsp_pkg::ACT_LOAD) begin
      // Drop writes that fall outside the graph.
      if (c.row < VERTICES && c.col < VERTICES) begin
        edge_table[int'(c.row) * VERTICES + int'(c.col)] = c.weight;
        loads_done++;
      end else begin
        dropped_items++;
      end
    end else if (c.source >= VERTICES) begin
      dropped_items++;
    end else begin
      solve_paths(int'(c.source));
      runs_done++;
    end
  endtask

  task automatic report_error(input string what, input int vtx, input longint got,
                              input longint want);
    if (errors < REPORT_CAP)
      $display("mismatch at %0t: %s, vertex %0d, got %0d, expected %0d",
               $realtime, what, vtx, got, want);
    errors++;
  endtask

  // Driver, sampling side: take the head item when the handshake completes.
  always @(posedge clk_i) begin
    if (rst_ni && cmd_bus.valid && cmd_bus.ready) begin
      apply_cmd(pending_cmds.pop_front());
      cmd_taken = 1'b1;
      cmds_sent++;
    end
  end

  // Driver, driving side: hold an offered item until taken, then idle for the
  // chosen gap before offering the next one.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      cmd_bus.valid <= 1'b0;
    end else if (!cmd_bus.valid || cmd_taken) begin
      cmd_taken = 1'b0;
      if (cmd_gap > 0) begin
        cmd_gap--;
        cmd_bus.valid <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        cmd_bus.valid  <= 1'b1;
        cmd_bus.action <= pending_cmds[0].action;
        cmd_bus.row    <= pending_cmds[0].row;
        cmd_bus.col    <= pending_cmds[0].col;
        cmd_bus.weight <= pending_cmds[0].weight;
        cmd_bus.src    <= pending_cmds[0].source;
        // Flip between calm and gappy stretches now and then.
        if ($urandom_range(0, 29) == 0) cmd_calm = !cmd_calm;
        cmd_gap = pick_gap(cmd_calm);
      end else begin
        cmd_bus.valid <= 1'b0;
      end
    end
  end

  // Monitor, ready side: stall the result channel at random.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      res_bus.ready <= 1'b0;
    end else if (res_stall > 0) begin
      res_stall--;
      res_bus.ready <= 1'b0;
    end else begin
      res_bus.ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) begin
        if ($urandom_range(0, 29) == 0) res_calm = !res_calm;
        res_stall = pick_gap(res_calm);
      end
    end
  end

  // Monitor, checking side: compare each accepted result with the oldest
  // expectation, field by field.
  always @(posedge clk_i) begin
    vertex_result_t want;
    if (rst_ni && res_bus.valid && res_bus.ready) begin
      results_seen++;
      if (!res_bus.reachable) unreachable_seen++;
      if (expected_vertices.size() == 0) begin
        report_error("result with nothing expected", res_bus.vertex, res_bus.distance, 0);
      end else begin
        want = expected_vertices.pop_front();
        if (res_bus.vertex !== want.vertex)
          report_error("vertex", want.vertex, res_bus.vertex, want.vertex);
        if (res_bus.distance !== want.distance)
          report_error("distance", want.vertex, res_bus.distance, want.distance);
        if (res_bus.predecessor !== want.predecessor)
          report_error("predecessor", want.vertex, res_bus.predecessor, want.predecessor);
        if (res_bus.reachable !== want.reachable)
          report_error("reachable", want.vertex, res_bus.reachable, want.reachable);
        if (res_bus.last !== want.last)
          report_error("last", want.vertex, res_bus.last, want.last);
      end
    end
  end

  // Watchdog: count cycles with no handshake on either channel.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((cmd_bus.valid && cmd_bus.ready) || (res_bus.valid && res_bus.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", idle_cycles);
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    int pick;
    int n;
    int vtx;
    int random_count;

    // Known values on every input from time zero.
    rst_ni         = 1'b0;
    cmd_bus.valid  = 1'b0;
    cmd_bus.action = ddsp_pkg::ACT_LOAD;
    cmd_bus.row    = '0;
    cmd_bus.col    = '0;
    cmd_bus.weight = '0;
    cmd_bus.src    = '0;
    res_bus.ready  = 1'b0;
    cmds_sent      = 0;
    cmd_gap        = 0;
    cmd_taken      = 1'b0;
    cmd_calm       = 1'b0;
    res_stall      = 0;
    res_calm       = 1'b0;
    idle_cycles    = 0;
    errors         = 0;
    loads_done     = 0;
    runs_done      = 0;
    dropped_items  = 0;
    results_seen   = 0;
    unreachable_seen = 0;

    // Load every matrix entry before any run, so no run reads an unwritten one.
    for (int r = 0; r < VERTICES; r++)
      for (int c = 0; c < VERTICES; c++)
        queue_load(r, c, NO_EDGE);

    // Directed part. An empty graph first: only the source is reachable.
    queue_run(0);
    queue_load(0, 0, 16'd0);        // self edge of the source, must be ignored
    queue_load(0, 1, 16'd5);
    queue_load(0, 2, 16'd3);
    queue_load(0, 3, 16'd3);        // ties with vertex 2: lower index wins
    queue_load(2, 1, 16'd2);        // equal distance via 2, keep the direct path
    queue_load(3, 4, 16'd0);        // zero-weight edge
    queue_load(4, 5, 16'd65534);    // heaviest real edge
    queue_load(5, 15, 16'd65534);
    // Writes outside the graph; a wrapped index would corrupt entry 0,1, 1,0 or 15,15.
    queue_load(VERTICES, 1, 16'd0);
    queue_load(1, VERTICES, 16'd0);
    queue_load(63, 63, 16'd0);
    queue_run(0);
    queue_run(VERTICES);            // sources outside the graph are dropped
    queue_run(63);
    queue_run(15);                  // vertex 15 has no outgoing edges yet
    queue_load(15, 0, 16'd65534);
    queue_run(15);                  // long chain back round through 0
    queue_load(1, 0, 16'd0);        // zero edge back into a settled vertex
    queue_run(1);
    queue_run(2);

    // Random part: mostly edge updates followed by a run, plus row rewrites,
    // loads with no run, and noise outside the graph.
    random_count = 0;
    while (random_count < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 62) begin
        n = $urandom_range(1, 8);
        repeat (n)
          queue_load($urandom_range(0, VERTICES - 1), $urandom_range(0, VERTICES - 1),
                     pick_weight());
        queue_run($urandom_range(0, VERTICES - 1));
        random_count += n + 1;
      end else if (pick < 72) begin
        vtx = $urandom_range(0, VERTICES - 1);
        for (int c = 0; c < VERTICES; c++) queue_load(vtx, c, pick_weight());
        queue_run(vtx);
        random_count += VERTICES + 1;
      end else if (pick < 80) begin
        n = $urandom_range(1, 4);
        repeat (n)
          queue_load($urandom_range(0, VERTICES - 1), $urandom_range(0, VERTICES - 1),
                     pick_weight());
        random_count += n;
      end else if (pick < 90) begin
        if ($urandom_range(0, 1))
          queue_load($urandom_range(VERTICES, 63), $urandom_range(0, 63),
                     WEIGHT_W'($urandom_range(0, 65535)));
        else
          queue_load($urandom_range(0, 63), $urandom_range(VERTICES, 63),
                     WEIGHT_W'($urandom_range(0, 65535)));
        random_count += 1;
      end else begin
        queue_run($urandom_range(VERTICES, 63));
        random_count += 1;
      end
    end
    cmds_total = pending_cmds.size();

    // Hold reset, then release it away from the rising edge.
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Wait for every item to go in and every result to come out, then let
    // the block settle in case the last item started work with no results.
    while (cmds_sent < cmds_total) @(posedge clk_i);
    while (expected_vertices.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (expected_vertices.size() != 0)
      report_error("results never arrived", 0, 0, expected_vertices.size());

    $display("covered %0d weight loads, %0d runs and %0d dropped items",
             loads_done, runs_done, dropped_items);
    $display("checked %0d vertex results, %0d of them unreachable, %0d errors",
             results_seen, unreachable_seen, errors);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
